### rtl/bounded_deque_with_value_delete_macros.svh
// assertion macros shared by the deque modules
`ifndef BOUNDED_DEQUE_WITH_VALUE_DELETE_MACROS_SVH
`define BOUNDED_DEQUE_WITH_VALUE_DELETE_MACROS_SVH

`ifndef SYNTH
// checked outside reset
`define BDQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked at every edge, reset included
`define BDQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BDQ_ASSERT(lbl, prop, msg)
`define BDQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/bdq_pkg.sv
// shared types, constants and helpers of the bounded deque
package bdq_pkg;

	// number of element slots
	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > 5) ? CNT_W : 5;
	localparam int DATA_W   = 32;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	// request codes
	typedef enum logic [3:0] {
		MODE_PUSH_FRONT  = 4'd0,
		MODE_PUSH_BACK   = 4'd1,
		MODE_POP_FRONT   = 4'd2,
		MODE_POP_BACK    = 4'd3,
		MODE_DELETE      = 4'd4,
		MODE_CLEAR       = 4'd5,
		MODE_READ_ALL    = 4'd6,
		MODE_READ_FIRST  = 4'd7,
		MODE_READ_LAST   = 4'd8
	} mode_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} stat_t;

	// controller to datapath
	typedef struct packed {
		logic  take_req;
		logic  load_n;
		logic  walk_start;
		logic  walk_next;
		logic  del_step;
		logic  del_done;
		logic  push_front;
		logic  push_back;
		logic  pop_front;
		logic  pop_back;
		logic  clear;
		logic  set_stat;
		stat_t stat;
		logic  emit_item;
		logic  emit_stat;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [3:0] mode;
		logic       full;
		logic       empty;
		logic       n_zero;
		logic       walk_last;
		logic       found;
		logic       out_free;
	} sts_t;

	// circular slot of a position counted from the front
	function automatic logic [IDX_W-1:0] slot_of(logic [IDX_W-1:0] front,
		logic [IDX_W-1:0] pos);
		logic [IDX_W:0] sum;
		sum = {1'b0, front} + {1'b0, pos};
		if (sum >= (IDX_W+1)'(CAPACITY)) begin
			sum = sum - (IDX_W+1)'(CAPACITY);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

### rtl/bdq_ram.sv
// generic single write, single read ram with registered read data
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/bdq_ctrl.sv
// request sequencer of the bounded deque
`include "bounded_deque_with_value_delete_macros.svh"

module bdq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  bdq_pkg::sts_t sts,
	output bdq_pkg::cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EXEC = 5'b00010,
		S_DEL  = 5'b00100,
		S_RD   = 5'b01000,
		S_STAT = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// requests are taken only between operations
	assign in_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		cmd     = '0;
		cmd.stat = bdq_pkg::ST_OK;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take_req = 1'b1;
					state_d      = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d  = S_STAT;
				cmd.set_stat = 1'b1;
				case (sts.mode)
					bdq_pkg::MODE_PUSH_FRONT: begin
						if (sts.full) begin
							cmd.stat = bdq_pkg::ST_FULL;
						end else begin
							cmd.push_front = 1'b1;
						end
					end
					bdq_pkg::MODE_PUSH_BACK: begin
						if (sts.full) begin
							cmd.stat = bdq_pkg::ST_FULL;
						end else begin
							cmd.push_back = 1'b1;
						end
					end
					bdq_pkg::MODE_POP_FRONT: begin
						if (sts.empty) begin
							cmd.stat = bdq_pkg::ST_EMPTY;
						end else begin
							cmd.pop_front = 1'b1;
						end
					end
					bdq_pkg::MODE_POP_BACK: begin
						if (sts.empty) begin
							cmd.stat = bdq_pkg::ST_EMPTY;
						end else begin
							cmd.pop_back = 1'b1;
						end
					end
					bdq_pkg::MODE_DELETE: begin
						if (sts.empty) begin
							cmd.stat = bdq_pkg::ST_EMPTY;
						end else begin
							cmd.set_stat   = 1'b0;
							cmd.load_n     = 1'b1;
							cmd.walk_start = 1'b1;
							state_d        = S_DEL;
						end
					end
					bdq_pkg::MODE_CLEAR: begin
						cmd.clear = 1'b1;
					end
					bdq_pkg::MODE_READ_ALL,
					bdq_pkg::MODE_READ_FIRST,
					bdq_pkg::MODE_READ_LAST: begin
						if (sts.n_zero) begin
							cmd.stat = sts.empty ? bdq_pkg::ST_EMPTY : bdq_pkg::ST_OK;
						end else begin
							cmd.set_stat   = 1'b0;
							cmd.load_n     = 1'b1;
							cmd.walk_start = 1'b1;
							state_d        = S_RD;
						end
					end
					default: begin
						cmd.stat = bdq_pkg::ST_OK;
					end
				endcase
			end
			// one stored element per cycle, shifting down after the match
			S_DEL: begin
				cmd.del_step = 1'b1;
				if (sts.walk_last) begin
					cmd.del_done = 1'b1;
					cmd.set_stat = 1'b1;
					cmd.stat     = sts.found ? bdq_pkg::ST_OK : bdq_pkg::ST_NOTFOUND;
					state_d      = S_STAT;
				end else begin
					cmd.walk_next = 1'b1;
				end
			end
			// element read-out, paced by the output register
			S_RD: begin
				if (sts.out_free) begin
					cmd.emit_item = 1'b1;
					if (sts.walk_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.walk_next = 1'b1;
					end
				end
			end
			S_STAT: begin
				if (sts.out_free) begin
					cmd.emit_stat = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`BDQ_ASSERT(a_accept_exec, (in_valid && !in_stall) |=> (state_q == S_EXEC), "accepted request not executed")

endmodule

### rtl/bdq_dp.sv
// element store, pointers, walk counter and output register of the deque
`include "bounded_deque_with_value_delete_macros.svh"

module bdq_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [3:0]          mode,
	input  logic signed [31:0]  operand_value,
	input  logic [4:0]          read_count,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [31:0]  item_value,
	output logic                item_valid,
	output logic                last_item,
	output logic [1:0]          status,
	output logic [4:0]          occupancy,
	input  bdq_pkg::cmd_t       cmd,
	output bdq_pkg::sts_t       sts
);

	localparam int IDX_W = bdq_pkg::IDX_W;
	localparam int CNT_W = bdq_pkg::CNT_W;
	localparam int CMP_W = bdq_pkg::CMP_W;

	// request registers
	logic [3:0]                   mode_q;
	logic [bdq_pkg::DATA_W-1:0]   val_q;
	logic [4:0]                   rcnt_q;

	// deque state
	logic [IDX_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;

	// walk state
	logic [IDX_W-1:0] i_q;
	logic [CNT_W-1:0] n_q;
	logic             found_q;
	logic [1:0]       stat_q;

	// output register
	logic                       ovalid_q;
	logic [bdq_pkg::DATA_W-1:0] ovalue_q;
	logic                       oitem_q;
	logic                       olast_q;
	logic [1:0]                 ostat_q;
	logic [CNT_W-1:0]           oocc_q;

	logic                       ram_we;
	logic [IDX_W-1:0]           ram_waddr;
	logic [bdq_pkg::DATA_W-1:0] ram_wdata;
	logic                       ram_re;
	logic [IDX_W-1:0]           ram_raddr;
	logic [bdq_pkg::DATA_W-1:0] ram_rdata;

	logic [IDX_W-1:0] front_dec;
	logic [IDX_W-1:0] front_inc;
	logic [CNT_W-1:0] n_next;
	logic [CNT_W-1:0] rd_idx;
	logic [CNT_W-1:0] rd_pos;
	logic             rev;
	logic             match;
	logic             out_free;

	// neighbor slots of the front
	assign front_dec = (front_q == '0) ? IDX_W'(bdq_pkg::CAPACITY - 1) : front_q - 1'b1;
	assign front_inc = (front_q == IDX_W'(bdq_pkg::CAPACITY - 1)) ? '0 : front_q + 1'b1;

	// number of elements a walk covers
	always_comb begin
		n_next = count_q;
		if ((mode_q == bdq_pkg::MODE_READ_FIRST || mode_q == bdq_pkg::MODE_READ_LAST) &&
			(CMP_W'(rcnt_q) < CMP_W'(count_q))) begin
			n_next = CNT_W'(rcnt_q);
		end
	end

	// read address: next position of the walk, tail first for last-n
	assign rev    = (mode_q == bdq_pkg::MODE_READ_LAST);
	assign rd_idx = cmd.walk_start ? '0 : CNT_W'(i_q) + 1'b1;
	assign rd_pos = rev ? (count_q - 1'b1 - rd_idx) : rd_idx;
	assign ram_re    = cmd.walk_start | cmd.walk_next;
	assign ram_raddr = bdq_pkg::slot_of(front_q, rd_pos[IDX_W-1:0]);

	// write address: pushes and the shift-down after a deleted match
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = bdq_pkg::slot_of(front_q, i_q - 1'b1);
		ram_wdata = ram_rdata;
		if (cmd.push_front) begin
			ram_we    = 1'b1;
			ram_waddr = front_dec;
			ram_wdata = val_q;
		end else if (cmd.push_back) begin
			ram_we    = 1'b1;
			ram_waddr = bdq_pkg::slot_of(front_q, count_q[IDX_W-1:0]);
			ram_wdata = val_q;
		end else if (cmd.del_step && found_q) begin
			ram_we = 1'b1;
		end
	end

	assign match    = !found_q && (ram_rdata == val_q);
	assign out_free = !ovalid_q || !out_stall;

	// status to the controller
	always_comb begin
		sts.mode      = mode_q;
		sts.full      = (count_q == bdq_pkg::CAP_CNT);
		sts.empty     = (count_q == '0);
		sts.n_zero    = (n_next == '0);
		sts.walk_last = ((CNT_W'(i_q) + 1'b1) == n_q);
		sts.found     = found_q | match;
		sts.out_free  = out_free;
	end

	bdq_ram #(
		.WIDTH (bdq_pkg::DATA_W),
		.DEPTH (bdq_pkg::CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// pointers, walk counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			count_q  <= '0;
			i_q      <= '0;
			n_q      <= '0;
			found_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (cmd.push_front) begin
				front_q <= front_dec;
				count_q <= count_q + 1'b1;
			end
			if (cmd.push_back) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.pop_front) begin
				front_q <= front_inc;
				count_q <= count_q - 1'b1;
			end
			if (cmd.pop_back) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.clear) begin
				front_q <= '0;
				count_q <= '0;
			end
			if (cmd.del_done && (found_q || match)) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.load_n) begin
				n_q <= n_next;
			end
			if (cmd.walk_start) begin
				i_q     <= '0;
				found_q <= 1'b0;
			end else if (cmd.walk_next) begin
				i_q <= i_q + 1'b1;
			end
			if (cmd.del_step && match) begin
				found_q <= 1'b1;
			end
			if (cmd.emit_item || cmd.emit_stat) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (cmd.take_req) begin
			mode_q <= mode;
			val_q  <= operand_value;
			rcnt_q <= read_count;
		end
		if (cmd.set_stat) begin
			stat_q <= cmd.stat;
		end
		if (cmd.emit_item) begin
			ovalue_q <= ram_rdata;
			oitem_q  <= 1'b1;
			olast_q  <= sts.walk_last;
			ostat_q  <= bdq_pkg::ST_OK;
			oocc_q   <= count_q;
		end else if (cmd.emit_stat) begin
			ovalue_q <= '0;
			oitem_q  <= 1'b0;
			olast_q  <= 1'b1;
			ostat_q  <= stat_q;
			oocc_q   <= count_q;
		end
	end

	assign out_valid  = ovalid_q;
	assign item_value = ovalue_q;
	assign item_valid = oitem_q;
	assign last_item  = olast_q;
	assign status     = ostat_q;
	assign occupancy  = 5'(oocc_q);

	`BDQ_ASSERT_ALWAYS(a_count_bound, !arst_n || (count_q <= bdq_pkg::CAP_CNT), "count high")
	`BDQ_ASSERT(a_emit_free, (cmd.emit_item || cmd.emit_stat) |-> out_free, "result overwrites pending transfer")
	`BDQ_ASSERT(a_shift_pos, (cmd.del_step && found_q) |-> (i_q != '0), "shift writes before the front")

endmodule

### rtl/bounded_deque_with_value_delete.sv
// top level of the bounded double-ended queue with delete by value
// Bounded deque of 32-bit signed words in a 16-entry circular ram. One request is
// taken at a time: a transfer on the input channel is followed by the execute state,
// and the block takes the next request once the last result of this one sits in the
// output register. Push, pop and clear pass from the execute state to the status
// state, which loads their status result. Delete by value walks the stored elements
// through the single ram read port, one per cycle, shifting later elements down
// behind the match. A read-out emits one element per cycle while the output side
// does not stall. The element ram is not cleared at reset; only occupied slots are
// ever read.
module bounded_deque_with_value_delete (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         mode,
	input  logic signed [31:0] operand_value,
	input  logic [4:0]         read_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] item_value,
	output logic               item_valid,
	output logic               last_item,
	output logic [1:0]         status,
	output logic [4:0]         occupancy
);

	bdq_pkg::cmd_t cmd;
	bdq_pkg::sts_t sts;

	bdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bdq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.mode          (mode),
		.operand_value (operand_value),
		.read_count    (read_count),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.item_value    (item_value),
		.item_valid    (item_valid),
		.last_item     (last_item),
		.status        (status),
		.occupancy     (occupancy),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule
